@@ rtl/pcm_volume_upsample_converter_assert.svh @@
// ---------------------------------------------------------------------------
// pcm volume upsample converter assertion macros
// shared concurrent assertion forms, switched off by NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef PCM_VOLUME_UPSAMPLE_CONVERTER_ASSERT_SVH
`define PCM_VOLUME_UPSAMPLE_CONVERTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PCMVU_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define PCMVU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define PCMVU_ASSERT_SAME(label, ante, cons)
`define PCMVU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/pcmvu_pkg.sv @@
// ---------------------------------------------------------------------------
// pcmvu_pkg
// shared types and constants of the pcm volume upsample converter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcmvu_pkg;

	localparam int SampleW = 16;
	localparam int VolumeW = 10;
	localparam int OperandW = SampleW + 1;
	localparam int ProductW = OperandW + VolumeW + 1;
	localparam int CfgIndexW = 2;
	localparam int ByteOffset = 128;
	localparam int GainShift = 8;

	typedef enum logic [CfgIndexW-1:0] {
		CFG_SAMPLE_IS_16BIT = 2'd0,
		CFG_STEREO          = 2'd1,
		CFG_DOUBLE_RATE     = 2'd2,
		CFG_VOLUME          = 2'd3
	} cfg_index_t;

	localparam logic [VolumeW-1:0] VolumeReset = 10'd256;

	typedef struct packed {
		logic               load;
		logic               advance;
		logic               enable;
		logic               is_16bit;
		logic [VolumeW-1:0] volume;
	} lane_ctrl_t;

	typedef struct packed {
		logic [SampleW-1:0] cur;
		logic [SampleW-1:0] mid;
	} lane_result_t;

endpackage

@@ rtl/pcm_volume_upsample_converter.sv @@
// ---------------------------------------------------------------------------
// pcm_volume_upsample_converter
// pcm gain scaler with optional 2x linear upsampling
// ---------------------------------------------------------------------------
// usage:
//  in channel (in_valid/in_ready) takes one frame word: left_raw, right_raw,
//  first_frame. out channel (out_valid/out_ready) gives result words with
//  left_out, right_out, interpolated and last.
//  cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the mode
//  and volume registers; cfg_ready is always high, write only when idle.
// path: an accepted frame's gain product is registered in the frame stage,
//  then its result words are registered in the output stage once it has space.
// throughput: one frame per cycle while out_ready is high and no midpoint is
//  made; in double rate mode a non-first frame gives two words, and the single
//  output word register takes the next frame as the frame word leaves.
// reset: registers take their reset values (16-bit, mono, single rate,
//  volume 256), previous samples are cleared, both pipeline stages empty.
// stall: while out_ready is low the output word holds; the frame stage
//  still takes one new word, then in_ready drops until space frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_volume_upsample_converter (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [pcmvu_pkg::CfgIndexW-1:0]               cfg_index,
	input  logic [pcmvu_pkg::VolumeW-1:0]                 cfg_data,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic [pcmvu_pkg::SampleW-1:0]                 left_raw,
	input  logic [pcmvu_pkg::SampleW-1:0]                 right_raw,
	input  logic                                          first_frame,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic signed [pcmvu_pkg::SampleW-1:0]          left_out,
	output logic signed [pcmvu_pkg::SampleW-1:0]          right_out,
	output logic                                          interpolated,
	output logic                                          last
);

`include "pcm_volume_upsample_converter_assert.svh"

	logic                          is_16bit_q;
	logic                          stereo_q;
	logic                          double_rate_q;
	logic [pcmvu_pkg::VolumeW-1:0] volume_q;
	logic                          valid_s1;
	logic                          first_s1;
	logic                          advance;
	logic                          in_fire;
	pcmvu_pkg::lane_ctrl_t         left_ctrl;
	pcmvu_pkg::lane_ctrl_t         right_ctrl;
	pcmvu_pkg::lane_result_t       left_res;
	pcmvu_pkg::lane_result_t       right_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_16bit_q <= 1'b1;
			stereo_q <= 1'b0;
			double_rate_q <= 1'b0;
			volume_q <= pcmvu_pkg::VolumeReset;
		end else if (cfg_valid) begin
			unique case (pcmvu_pkg::cfg_index_t'(cfg_index))
				pcmvu_pkg::CFG_SAMPLE_IS_16BIT: is_16bit_q <= cfg_data[0];
				pcmvu_pkg::CFG_STEREO:          stereo_q <= cfg_data[0];
				pcmvu_pkg::CFG_DOUBLE_RATE:     double_rate_q <= cfg_data[0];
				pcmvu_pkg::CFG_VOLUME:          volume_q <= cfg_data;
				default:                        volume_q <= volume_q;
			endcase
		end
	end

	assign in_ready = !valid_s1 || advance;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			first_s1 <= first_frame;
		end
	end

	always_comb begin
		left_ctrl.load = in_fire;
		left_ctrl.advance = advance;
		left_ctrl.enable = 1'b1;
		left_ctrl.is_16bit = is_16bit_q;
		left_ctrl.volume = volume_q;
		right_ctrl = left_ctrl;
		right_ctrl.enable = stereo_q;
	end

	pcmvu_lane u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (left_ctrl),
		.raw    (left_raw),
		.result (left_res)
	);

	pcmvu_lane u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (right_ctrl),
		.raw    (right_raw),
		.result (right_res)
	);

	pcmvu_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.first_s1     (first_s1),
		.double_rate  (double_rate_q),
		.left_res     (left_res),
		.right_res    (right_res),
		.advance      (advance),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_out     (left_out),
		.right_out    (right_out),
		.interpolated (interpolated),
		.last         (last)
	);

	// midpoint word is never the last word of its frame
	`PCMVU_ASSERT_SAME(a_mid_not_last, out_valid && interpolated, !last)
	// a sent midpoint word is followed by its frame word
	`PCMVU_ASSERT_NEXT(a_mid_then_frame, out_valid && out_ready && interpolated,
		out_valid && !interpolated)
	// mono words carry a zero right sample
	`PCMVU_ASSERT_SAME(a_mono_right_zero, out_valid && !stereo_q, right_out == '0)
	// midpoints only in double rate mode
	`PCMVU_ASSERT_SAME(a_mid_needs_double, out_valid && interpolated, double_rate_q)

endmodule

@@ rtl/pcmvu_lane.sv @@
// ---------------------------------------------------------------------------
// pcmvu_lane
// one channel: gain multiply, truncating rescale, midpoint against previous
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcmvu_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pcmvu_pkg::lane_ctrl_t             ctrl,
	input  logic [pcmvu_pkg::SampleW-1:0]     raw,
	output pcmvu_pkg::lane_result_t           result
);

	logic signed [pcmvu_pkg::OperandW-1:0] operand;
	logic signed [pcmvu_pkg::VolumeW:0]    gain;
	logic signed [pcmvu_pkg::ProductW-1:0] product;
	logic signed [pcmvu_pkg::ProductW-1:0] product_s1;
	logic signed [pcmvu_pkg::ProductW-1:0] rounded;
	logic signed [pcmvu_pkg::ProductW-1:0] shifted;
	logic        [pcmvu_pkg::SampleW-1:0]  cur;
	logic        [pcmvu_pkg::SampleW-1:0]  prev_q;
	logic signed [pcmvu_pkg::SampleW:0]    cur_x;
	logic signed [pcmvu_pkg::SampleW:0]    prev_x;
	logic signed [pcmvu_pkg::SampleW:0]    diff;
	logic signed [pcmvu_pkg::SampleW:0]    half;
	logic signed [pcmvu_pkg::SampleW:0]    mid_x;

	always_comb begin
		if (ctrl.is_16bit) begin
			operand = pcmvu_pkg::OperandW'(signed'(raw));
		end else begin
			operand = signed'({{(pcmvu_pkg::OperandW-8){1'b0}}, raw[7:0]})
				- pcmvu_pkg::OperandW'(pcmvu_pkg::ByteOffset);
		end
		gain = signed'({1'b0, ctrl.volume});
		product = pcmvu_pkg::ProductW'(operand) * pcmvu_pkg::ProductW'(gain);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			product_s1 <= product;
		end
	end

	// truncate toward zero on the 16-bit path
	always_comb begin
		rounded = product_s1 + (product_s1[pcmvu_pkg::ProductW-1]
			? pcmvu_pkg::ProductW'((1 << pcmvu_pkg::GainShift) - 1)
			: pcmvu_pkg::ProductW'(0));
		shifted = rounded >>> pcmvu_pkg::GainShift;
		if (!ctrl.enable) begin
			cur = '0;
		end else if (ctrl.is_16bit) begin
			cur = shifted[pcmvu_pkg::SampleW-1:0];
		end else begin
			cur = product_s1[pcmvu_pkg::SampleW-1:0];
		end
	end

	always_comb begin
		cur_x = signed'({cur[pcmvu_pkg::SampleW-1], cur});
		prev_x = signed'({prev_q[pcmvu_pkg::SampleW-1], prev_q});
		diff = cur_x - prev_x;
		half = (diff + (diff[pcmvu_pkg::SampleW] ? (pcmvu_pkg::SampleW+1)'(1)
			: (pcmvu_pkg::SampleW+1)'(0))) >>> 1;
		mid_x = cur_x - half;
		result.cur = cur;
		result.mid = ctrl.enable ? mid_x[pcmvu_pkg::SampleW-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (ctrl.advance) begin
			prev_q <= cur;
		end
	end

endmodule

@@ rtl/pcmvu_merge.sv @@
// ---------------------------------------------------------------------------
// pcmvu_merge
// output stage: joins both lanes, sends a midpoint word, if any, then the frame word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcmvu_merge (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    valid_s1,
	input  logic                                    first_s1,
	input  logic                                    double_rate,
	input  pcmvu_pkg::lane_result_t                 left_res,
	input  pcmvu_pkg::lane_result_t                 right_res,
	output logic                                    advance,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [pcmvu_pkg::SampleW-1:0]    left_out,
	output logic signed [pcmvu_pkg::SampleW-1:0]    right_out,
	output logic                                    interpolated,
	output logic                                    last
);

	logic                          valid_q;
	logic                          has_mid_q;
	logic [pcmvu_pkg::SampleW-1:0] mid_l_q;
	logic [pcmvu_pkg::SampleW-1:0] mid_r_q;
	logic [pcmvu_pkg::SampleW-1:0] cur_l_q;
	logic [pcmvu_pkg::SampleW-1:0] cur_r_q;
	logic                          out_fire;
	logic                          space;

	assign out_fire = valid_q && out_ready;
	assign space = !valid_q || (out_fire && !has_mid_q);
	assign advance = valid_s1 && space;

	assign out_valid = valid_q;
	assign interpolated = has_mid_q;
	assign last = !has_mid_q;
	assign left_out = signed'(has_mid_q ? mid_l_q : cur_l_q);
	assign right_out = signed'(has_mid_q ? mid_r_q : cur_r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			has_mid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
			has_mid_q <= double_rate && !first_s1;
		end else if (out_fire) begin
			if (has_mid_q) begin
				has_mid_q <= 1'b0;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mid_l_q <= left_res.mid;
			mid_r_q <= right_res.mid;
			cur_l_q <= left_res.cur;
			cur_r_q <= right_res.cur;
		end
	end

endmodule

@@ sim/pcm_volume_upsample_checker.sv @@
// ---------------------------------------------------------------------------
// pcm_volume_upsample_checker
// watches the config, frame and result channels of the pcm volume upsample
// converter, keeps its own copy of the mode registers and previous samples,
// predicts the result words of every accepted frame and compares each
// accepted result word field by field against the oldest prediction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_volume_upsample_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [pcmvu_pkg::CfgIndexW-1:0]       cfg_index,
	input  logic [pcmvu_pkg::VolumeW-1:0]         cfg_data,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic [pcmvu_pkg::SampleW-1:0]         left_raw,
	input  logic [pcmvu_pkg::SampleW-1:0]         right_raw,
	input  logic                                  first_frame,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [pcmvu_pkg::SampleW-1:0]  left_out,
	input  logic signed [pcmvu_pkg::SampleW-1:0]  right_out,
	input  logic                                  interpolated,
	input  logic                                  last,
	output int                                    errors,
	output int                                    words_due
);

	typedef struct {
		logic signed [pcmvu_pkg::SampleW-1:0] left_out;
		logic signed [pcmvu_pkg::SampleW-1:0] right_out;
		logic                                 interpolated;
		logic                                 last;
	} pcm_word_t;

	pcm_word_t expected_words[$];

	logic                                 mode_16bit;
	logic                                 mode_stereo;
	logic                                 mode_double;
	logic [pcmvu_pkg::VolumeW-1:0]        gain;
	logic signed [pcmvu_pkg::SampleW-1:0] prev_left_smp;
	logic signed [pcmvu_pkg::SampleW-1:0] prev_right_smp;

	function automatic logic signed [pcmvu_pkg::SampleW-1:0] scaled_sample(
		input logic [pcmvu_pkg::SampleW-1:0] raw
	);
		logic signed [pcmvu_pkg::SampleW-1:0] s;
		int prod;
		s = raw;
		if (mode_16bit) begin
			prod = (int'(s) * int'(gain)) / (1 << pcmvu_pkg::GainShift);
		end else begin
			prod = (int'(raw[7:0]) - pcmvu_pkg::ByteOffset) * int'(gain);
		end
		return prod[pcmvu_pkg::SampleW-1:0];
	endfunction

	function automatic logic signed [pcmvu_pkg::SampleW-1:0] midpoint_sample(
		input logic signed [pcmvu_pkg::SampleW-1:0] cur,
		input logic signed [pcmvu_pkg::SampleW-1:0] prev
	);
		int c;
		int p;
		int m;
		c = int'(cur);
		p = int'(prev);
		m = c - (c - p) / 2;
		return m[pcmvu_pkg::SampleW-1:0];
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			errors++;
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pcm_word_t want;
		pcm_word_t word;
		logic signed [pcmvu_pkg::SampleW-1:0] cur_left;
		logic signed [pcmvu_pkg::SampleW-1:0] cur_right;
		if (!arst_n) begin
			mode_16bit = 1'b1;
			mode_stereo = 1'b0;
			mode_double = 1'b0;
			gain = pcmvu_pkg::VolumeReset;
			prev_left_smp = '0;
			prev_right_smp = '0;
			expected_words.delete();
			errors = 0;
			words_due <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					errors++;
					$error("unexpected word: left_out %0d right_out %0d", left_out, right_out);
				end else begin
					want = expected_words.pop_front();
					check_field("left_out", int'(want.left_out), int'(left_out));
					check_field("right_out", int'(want.right_out), int'(right_out));
					check_field("interpolated", int'(want.interpolated), int'(interpolated));
					check_field("last", int'(want.last), int'(last));
				end
			end
			if (in_valid && in_ready) begin
				cur_left = scaled_sample(left_raw);
				cur_right = mode_stereo ? scaled_sample(right_raw) : '0;
				if (mode_double && !first_frame) begin
					word.left_out = midpoint_sample(cur_left, prev_left_smp);
					word.right_out = mode_stereo ? midpoint_sample(cur_right, prev_right_smp) : '0;
					word.interpolated = 1'b1;
					word.last = 1'b0;
					expected_words.push_back(word);
				end
				word.left_out = cur_left;
				word.right_out = cur_right;
				word.interpolated = 1'b0;
				word.last = 1'b1;
				expected_words.push_back(word);
				prev_left_smp = cur_left;
				prev_right_smp = cur_right;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pcmvu_pkg::CFG_SAMPLE_IS_16BIT: mode_16bit = cfg_data[0];
					pcmvu_pkg::CFG_STEREO:          mode_stereo = cfg_data[0];
					pcmvu_pkg::CFG_DOUBLE_RATE:     mode_double = cfg_data[0];
					pcmvu_pkg::CFG_VOLUME:          gain = cfg_data;
					default: ;
				endcase
			end
			words_due <= expected_words.size();
		end
	end

endmodule

@@ sim/tb_pcm_volume_upsample_converter.sv @@
// ---------------------------------------------------------------------------
// tb_pcm_volume_upsample_converter
// drives the pcm volume upsample converter with directed frames covering
// sample extremes, gain wrap, 8-bit low-byte use, mono, unmarked first frame
// and mode changes mid-clip, then random clips under a sweep of register
// settings with random stalls on both channels and a long output hold-off;
// result words are checked by the checker module
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pcm_volume_upsample_converter;

	localparam int CycleLimit = 200000;
	localparam int HoldCycles = 60;
	localparam int RandomFrames = 330;
	localparam int DrainCycles = 8;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [pcmvu_pkg::CfgIndexW-1:0]      cfg_index = '0;
	logic [pcmvu_pkg::VolumeW-1:0]        cfg_data = '0;
	logic                                 in_valid = 1'b0;
	logic                                 in_ready;
	logic [pcmvu_pkg::SampleW-1:0]        left_raw = '0;
	logic [pcmvu_pkg::SampleW-1:0]        right_raw = '0;
	logic                                 first_frame = 1'b0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic signed [pcmvu_pkg::SampleW-1:0] left_out;
	logic signed [pcmvu_pkg::SampleW-1:0] right_out;
	logic                                 interpolated;
	logic                                 last;

	int  errors;
	int  words_due;
	int  cycle_count = 0;
	int  send_idle_pct = 22;
	int  recv_idle_pct = 53;
	logic hold_out_req = 1'b0;

	pcm_volume_upsample_converter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_raw     (left_raw),
		.right_raw    (right_raw),
		.first_frame  (first_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_out     (left_out),
		.right_out    (right_out),
		.interpolated (interpolated),
		.last         (last)
	);

	pcm_volume_upsample_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_raw     (left_raw),
		.right_raw    (right_raw),
		.first_frame  (first_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_out     (left_out),
		.right_out    (right_out),
		.interpolated (interpolated),
		.last         (last),
		.errors       (errors),
		.words_due    (words_due)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("tb_pcm_volume_upsample_converter failed");
			$finish;
		end
	end

	// result receiver, with one long hold-off on request
	initial begin
		int hold_count;
		logic held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_out_req && !held) begin
				held = 1'b1;
				for (hold_count = 0; hold_count < HoldCycles; hold_count++) begin
					out_ready <= 1'b0;
					@(posedge clk);
				end
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic write_reg(input pcmvu_pkg::cfg_index_t idx,
		input logic [pcmvu_pkg::VolumeW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic is16, input logic st, input logic dr,
		input logic [pcmvu_pkg::VolumeW-1:0] vol);
		write_reg(pcmvu_pkg::CFG_SAMPLE_IS_16BIT, {{(pcmvu_pkg::VolumeW-1){1'b0}}, is16});
		write_reg(pcmvu_pkg::CFG_STEREO, {{(pcmvu_pkg::VolumeW-1){1'b0}}, st});
		write_reg(pcmvu_pkg::CFG_DOUBLE_RATE, {{(pcmvu_pkg::VolumeW-1){1'b0}}, dr});
		write_reg(pcmvu_pkg::CFG_VOLUME, vol);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame(input logic [pcmvu_pkg::SampleW-1:0] l,
		input logic [pcmvu_pkg::SampleW-1:0] r, input logic first);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_raw <= l;
		right_raw <= r;
		first_frame <= first;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering words, wait for every expected result, then let the pipe settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_due != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic logic [pcmvu_pkg::SampleW-1:0] random_raw();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			3: return 16'hFFFF;
			default: return pcmvu_pkg::SampleW'($urandom);
		endcase
	endfunction

	function automatic logic [pcmvu_pkg::VolumeW-1:0] random_volume();
		case ($urandom_range(0, 7))
			0: return 10'd0;
			1: return 10'd1023;
			2: return pcmvu_pkg::VolumeReset;
			3: return 10'd1;
			default: return pcmvu_pkg::VolumeW'($urandom_range(0, 1023));
		endcase
	endfunction

	initial begin
		int sent;
		int phase_frames;
		int phase_len;
		int clip_len;
		logic first;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// unmarked frame right after reset, full-scale samples
		configure(1'b1, 1'b1, 1'b1, pcmvu_pkg::VolumeReset);
		send_frame(16'h7FFF, 16'h8000, 1'b0);
		send_frame(16'h8000, 16'h7FFF, 1'b0);
		send_frame(16'hFFFF, 16'h0001, 1'b1);
		send_frame(16'h0000, 16'hFFFF, 1'b0);
		wait_idle();
		// gain wrap on 16-bit
		configure(1'b1, 1'b1, 1'b1, 10'd1023);
		send_frame(16'h7FFF, 16'h8000, 1'b0);
		send_frame(16'h0100, 16'hFF00, 1'b0);
		wait_idle();
		// 8-bit mono mid-clip, high byte ignored
		configure(1'b0, 1'b0, 1'b1, 10'd1023);
		send_frame(16'hFF00, 16'h12FF, 1'b0);
		send_frame(16'h00FF, 16'hFFFF, 1'b0);
		send_frame(16'hAB80, 16'h5555, 1'b1);
		send_frame(16'h5A7F, 16'hAAAA, 1'b0);
		wait_idle();
		configure(1'b0, 1'b1, 1'b0, 10'd0);
		send_frame(16'hFFFF, 16'h0000, 1'b0);
		send_frame(16'h0001, 16'hFF80, 1'b1);
		wait_idle();
		configure(1'b1, 1'b0, 1'b0, 10'd1);
		send_frame(16'h8000, 16'h7FFF, 1'b0);
		send_frame(16'h00FF, 16'h8000, 1'b1);
		wait_idle();
		configure(1'b1, 1'b1, 1'b1, 10'd511);
		send_frame(16'hFF01, 16'h0100, 1'b0);
		send_frame(16'h8001, 16'h7FFE, 1'b0);

		for (int stage = 0; stage < 3; stage++) begin
			case (stage)
				0: begin send_idle_pct = 22; recv_idle_pct = 53; end
				1: begin send_idle_pct = 53; recv_idle_pct = 22; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			sent = 0;
			while (sent < RandomFrames / 3) begin
				wait_idle();
				configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					$urandom_range(0, 3) != 0, random_volume());
				phase_len = $urandom_range(20, 50);
				phase_frames = 0;
				while (phase_frames < phase_len) begin
					clip_len = $urandom_range(1, 12);
					for (int i = 0; i < clip_len; i++) begin
						first = (i == 0);
						if ($urandom_range(0, 9) == 0)
							first = 1'($urandom_range(0, 1));
						if (stage == 2 && phase_frames + i >= 4)
							hold_out_req <= 1'b1;
						send_frame(random_raw(), random_raw(), first);
					end
					phase_frames += clip_len;
				end
				sent += phase_frames;
			end
		end

		wait_idle();
		if (errors == 0)
			$display("tb_pcm_volume_upsample_converter passed");
		else
			$display("tb_pcm_volume_upsample_converter failed");
		$finish;
	end

endmodule
